// File: hw/rtl/min_priority_queue_core_assert.svh
`ifndef MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue port check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define MPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue port check failed");

`endif

// File: hw/rtl/mpq_pkg.sv
package mpq_pkg;

	localparam int CAPACITY = 256;
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 32;
	localparam int OCC_W    = 9;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

	localparam entry_t EMPTY_E = '{valid: 1'b0, prio: '0, data: '0};

endpackage

// File: hw/rtl/mpq_cell.sv
module mpq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mpq_pkg::cell_ctl_t ctl,
	input  mpq_pkg::entry_t   new_e,
	input  mpq_pkg::entry_t   left_e,
	input  logic              left_gt,
	input  mpq_pkg::entry_t   right_e,
	output mpq_pkg::entry_t   cur_e,
	output logic              gt
);

	logic            valid_q;
	logic [mpq_pkg::PRIO_W-1:0] prio_q;
	logic [mpq_pkg::DATA_W-1:0] data_q;
	mpq_pkg::entry_t nxt_e;

	assign cur_e = '{valid: valid_q, prio: prio_q, data: data_q};

	// Strict compare keeps equal priorities in arrival order.
	assign gt = !valid_q || ($signed(new_e.prio) < $signed(prio_q));

	always_comb begin
		nxt_e = cur_e;
		if (ctl.del) begin
			nxt_e = right_e;
		end else if (ctl.ins && gt) begin
			// Insertion point takes the new pair, cells behind it shift back.
			nxt_e = left_gt ? left_e : new_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt_e.prio;
		data_q <= nxt_e.data;
	end

endmodule

// File: hw/rtl/min_priority_queue_core.sv
// A result strobes on done in the cycle after start is taken.
// Throughput: one command per cycle; every cell of the sorted chain settles in
// the cycle of the transfer, so busy never rises.
// Reset: arst_n clears every cell's valid bit and the count; the queue is empty.
// The result is shown for one cycle only, the receiver cannot stall it.
module min_priority_queue_core #(
	parameter int CAPACITY = mpq_pkg::CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic signed [mpq_pkg::DATA_W-1:0]  item_data,
	input  logic signed [mpq_pkg::PRIO_W-1:0]  item_priority,
	output logic                               done,
	output logic signed [mpq_pkg::DATA_W-1:0]  out_data,
	output logic signed [mpq_pkg::PRIO_W-1:0]  out_priority,
	output logic [1:0]                         status,
	output logic [mpq_pkg::OCC_W-1:0]          occupancy
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_nxt;
	logic               take;
	logic               is_full;
	logic               is_empty;
	mpq_pkg::cell_ctl_t ctl;
	mpq_pkg::entry_t    new_e;
	mpq_pkg::entry_t    cell_e [CAPACITY];
	logic               cell_gt [CAPACITY];
	mpq_pkg::status_t   st_nxt;

	logic                      done_q;
	logic [mpq_pkg::DATA_W-1:0] data_q;
	logic [mpq_pkg::PRIO_W-1:0] prio_q;
	logic [1:0]                status_q;
	logic [mpq_pkg::OCC_W-1:0] occ_q;

	assign busy     = 1'b0;
	assign take     = start && !busy;
	assign is_full  = (cnt_q == CNT_W'(CAPACITY));
	assign is_empty = (cnt_q == '0);
	assign new_e    = '{valid: 1'b1, prio: item_priority, data: item_data};

	always_comb begin
		ctl     = '{ins: 1'b0, del: 1'b0};
		cnt_nxt = cnt_q;
		st_nxt  = mpq_pkg::ST_ENQ;
		if (command == mpq_pkg::CMD_ENQ) begin
			if (is_full) begin
				st_nxt = mpq_pkg::ST_FULL;
			end else begin
				ctl.ins = take;
				cnt_nxt = cnt_q + CNT_W'(1);
			end
		end else begin
			if (is_empty) begin
				st_nxt = mpq_pkg::ST_EMPTY;
			end else begin
				st_nxt  = mpq_pkg::ST_DEQ;
				ctl.del = take;
				cnt_nxt = cnt_q - CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mpq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_e   (new_e),
			.left_e  ((i == 0) ? mpq_pkg::EMPTY_E : cell_e[(i == 0) ? 0 : i - 1]),
			.left_gt ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.right_e ((i == CAPACITY - 1) ? mpq_pkg::EMPTY_E
			          : cell_e[(i == CAPACITY - 1) ? i : i + 1]),
			.cur_e   (cell_e[i]),
			.gt      (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	// Head cell holds the smallest priority; drive it out on a dequeue only.
	always_ff @(posedge clk) begin
		if (take) begin
			data_q   <= ctl.del ? cell_e[0].data : '0;
			prio_q   <= ctl.del ? cell_e[0].prio : '0;
			status_q <= st_nxt;
			occ_q    <= mpq_pkg::OCC_W'(cnt_nxt);
		end
	end

	assign done         = done_q;
	assign out_data     = data_q;
	assign out_priority = prio_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule

// File: hw/rtl/mpq_checker.sv
`include "min_priority_queue_core_assert.svh"

module mpq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         command,
	input logic                         done,
	input logic [mpq_pkg::DATA_W-1:0]   out_data,
	input logic [mpq_pkg::PRIO_W-1:0]   out_priority,
	input logic [1:0]                   status,
	input logic [mpq_pkg::OCC_W-1:0]    occupancy
);

	logic xfer;
	logic no_pair;
	logic deq_after_enq;
	logic deq_ok;

	assign xfer          = start && !busy;
	assign no_pair       = done && status != mpq_pkg::ST_DEQ;
	assign deq_after_enq = done && status == mpq_pkg::ST_ENQ && xfer
	                       && command == mpq_pkg::CMD_DEQ;
	assign deq_ok        = status == mpq_pkg::ST_DEQ;

	// Every transfer yields exactly one result on the next cycle.
	`MPQ_ASSERT_NEXT(a_one_result, xfer, done)
	`MPQ_ASSERT_NEXT(a_no_spurious, !xfer, !done)

	// Only a successful dequeue carries a pair.
	`MPQ_ASSERT_NOW(a_zero_payload, no_pair, out_data == '0 && out_priority == '0)

	// An empty report means nothing is held.
	`MPQ_ASSERT_NOW(a_empty_occ, done && status == mpq_pkg::ST_EMPTY, occupancy == '0)

	// A dequeue result that follows an enqueue result drops occupancy by one.
	`MPQ_ASSERT_NEXT(a_deq_occ, deq_after_enq, deq_ok && occupancy == $past(occupancy) - 9'd1)

endmodule

bind min_priority_queue_core mpq_checker u_mpq_checker (.*);
